// File: src/mdds_pkg.sv
// shared constants, types and the seven-segment decoder of the display scanner
`timescale 1ns / 1ps

package mdds_pkg;

    // number of decimal digits held in the store
    localparam int DIGITS       = 6;
    localparam int SLOT_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int BCD_W        = 4 * DIGITS;

    // transaction field widths
    localparam int VALUE_W      = 32;
    localparam int SLOT_FIELD_W = 3;
    localparam int PATTERN_W    = 7;
    localparam int PERIOD_W     = 8;
    localparam int S_TDATA_W    = VALUE_W;
    localparam int M_TDATA_W    = 16;
    localparam int M_PAD_W      = M_TDATA_W - SLOT_FIELD_W - PATTERN_W;

    // conversion step counter
    localparam int STEP_W       = $clog2(VALUE_W);

    // configuration port
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_REFRESH_PERIOD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_ENCODING = CFG_INDEX_W'(1);

    // register reset values
    localparam logic [PERIOD_W-1:0] REFRESH_PERIOD_RST = PERIOD_W'(2);
    localparam logic                ENC_BCD            = 1'b0;
    localparam logic                ENC_SEGMENT        = 1'b1;

    // item kinds carried in s_tuser
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_start;
        logic shift;
        logic store;
        logic tick;
    } mdds_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_blocked;
    } mdds_status_t;

    // decimal digit to segment pattern gfedcba
    function automatic logic [PATTERN_W-1:0] seg_encode(input logic [3:0] digit);
        logic [PATTERN_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h67;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

// File: src/mdds_datapath.sv
// datapath: shift-add-3 converter, digit store, scan prescaler and output register
`timescale 1ns / 1ps

module mdds_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mdds_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mdds_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [mdds_pkg::VALUE_W-1:0]      value,
    input  mdds_pkg::mdds_cmd_t               cmd,
    output mdds_pkg::mdds_status_t            status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mdds_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);
    import mdds_pkg::*;

    logic [PERIOD_W-1:0]  refresh_period_reg;
    logic                 digit_encoding_reg;

    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     bcd_adj;

    logic [PATTERN_W-1:0] store_reg  [DIGITS];
    logic [PATTERN_W-1:0] store_next [DIGITS];

    logic [PERIOD_W-1:0]  countdown_reg, countdown_next;
    logic [SLOT_W-1:0]    pos_reg, pos_next;
    logic                 fire;

    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [PATTERN_W-1:0] out_pattern_reg, out_pattern_next;
    logic                 out_first_reg, out_first_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_period_reg <= REFRESH_PERIOD_RST;
            digit_encoding_reg <= ENC_BCD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REFRESH_PERIOD: refresh_period_reg <= cfg_data[PERIOD_W-1:0];
                REG_DIGIT_ENCODING: digit_encoding_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    // converter: one binary bit enters the bcd register per step, top digits fall off
    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (cmd.load_start)
        begin
            bin_next = value;
            bcd_next = '0;
        end
        else if (cmd.shift)
        begin
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // digit store: bcd msd first, or segment patterns lsd first
    always_comb
    begin
        for (int k = 0; k < DIGITS; k++)
        begin
            store_next[k] = store_reg[k];
            if (cmd.store)
            begin
                if (digit_encoding_reg == ENC_SEGMENT)
                    store_next[k] = seg_encode(bcd_reg[4*k +: 4]);
                else
                    store_next[k] = {{(PATTERN_W-4){1'b0}}, bcd_reg[4*(DIGITS-1-k) +: 4]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIGITS; k++)
                store_reg[k] <= '0;
        end
        else
        begin
            for (int k = 0; k < DIGITS; k++)
                store_reg[k] <= store_next[k];
        end
    end

    // scan prescaler and slot position
    assign fire = cmd.tick && (countdown_reg == '0);

    always_comb
    begin
        countdown_next = countdown_reg;
        pos_next       = pos_reg;
        if (fire)
        begin
            countdown_next = (refresh_period_reg == '0) ? '0
                                                         : refresh_period_reg - 1'b1;
            pos_next       = (pos_reg == SLOT_W'(DIGITS - 1)) ? '0 : pos_reg + 1'b1;
        end
        else if (cmd.tick)
        begin
            countdown_next = countdown_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg <= PERIOD_W'(1);
            pos_reg       <= '0;
        end
        else
        begin
            countdown_reg <= countdown_next;
            pos_reg       <= pos_next;
        end
    end

    // output register, loaded when a tick fires
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_slot_next    = out_slot_reg;
        out_pattern_next = out_pattern_reg;
        out_first_next   = out_first_reg;
        if (fire)
        begin
            out_valid_next   = 1'b1;
            out_slot_next    = pos_reg;
            out_pattern_next = store_reg[pos_reg];
            out_first_next   = (pos_reg == '0);
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_slot_reg    <= out_slot_next;
        out_pattern_reg <= out_pattern_next;
        out_first_reg   <= out_first_next;
    end

    // status and master side
    assign status.out_blocked = out_valid_reg && !m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_pattern_reg,
                       SLOT_FIELD_W'(out_slot_reg)};
    assign m_tuser  = out_first_reg;

endmodule

// File: src/mdds_controller.sv
// controller: accepts transactions and sequences the decimal conversion
`timescale 1ns / 1ps

module mdds_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tuser,
    output logic                   s_tready,
    input  mdds_pkg::mdds_status_t status,
    output mdds_pkg::mdds_cmd_t    cmd
);
    import mdds_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_STORE
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              accept;

    // items are taken only when idle and the output register can take a result
    assign s_tready = (state_reg == ST_IDLE) && !status.out_blocked;
    assign accept   = s_tvalid && s_tready;

    // commands to the datapath
    assign cmd.load_start = accept && (s_tuser == KIND_LOAD);
    assign cmd.tick       = accept && (s_tuser == KIND_TICK);
    assign cmd.shift      = (state_reg == ST_CONVERT);
    assign cmd.store      = (state_reg == ST_STORE);

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (cmd.load_start)
                        state_reg <= ST_CONVERT;
                end
                ST_CONVERT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(VALUE_W - 1))
                        state_reg <= ST_STORE;
                end
                ST_STORE:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/multiplexed_decimal_display_scanner_top.sv
// Display scanner for a multiplexed six-digit decimal display. A load transaction
// (s_tuser low) converts s_tdata, taken modulo one million, into six decimal digits
// with a shift-add-3 converter that handles one binary bit per cycle, so a load
// keeps the slave side busy through the conversion steps and the store write
// before the next transaction is taken. A tick transaction (s_tuser high)
// counts down the prescaler; every refresh_period ticks it puts one result
// in the output register: the slot, its stored code, and in m_tuser whether the
// external digit counter gets a reset pulse (slot 0) or a clock pulse. A tick is
// accepted while a result waits only if that result is taken in the same cycle.
// Register 0 is refresh_period (0 acts as 1), register 1 selects bcd nibbles,
// msd in slot 0, or seven-segment patterns, lsd in slot 0, for later loads.
`timescale 1ns / 1ps

module multiplexed_decimal_display_scanner_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [mdds_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mdds_pkg::CFG_DATA_W-1:0]   cfg_data,
    // slave side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mdds_pkg::S_TDATA_W-1:0]    s_tdata,   // [31:0] value
    input  logic                              s_tuser,   // [0] kind
    // master side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mdds_pkg::M_TDATA_W-1:0]    m_tdata,   // [2:0] digit_slot, [9:3] digit_pattern
    output logic                              m_tuser    // [0] counter_reset
);
    import mdds_pkg::*;

    mdds_cmd_t    cmd;
    mdds_status_t status;

    // transaction control and conversion sequencing
    mdds_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // conversion, store, prescaler and output register
    mdds_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (s_tdata[VALUE_W-1:0]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: src/mdds_checker.sv
// port-level checks of the display scanner and their bind to the top level
`timescale 1ns / 1ps

module mdds_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mdds_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);
    import mdds_pkg::*;

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a load transaction occupies the converter in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_LOAD) |=> !s_tready)
        else $error("transaction taken during conversion");

    // slot stays inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[SLOT_FIELD_W-1:0] < SLOT_FIELD_W'(DIGITS)))
        else $error("slot beyond store");

    // reset pulse exactly on slot 0
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == (m_tdata[SLOT_FIELD_W-1:0] == '0)))
        else $error("counter pulse does not match slot");

    // ready is never offered while a stalled result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("transaction taken while output blocked");

endmodule

bind multiplexed_decimal_display_scanner_top mdds_checker u_mdds_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: sim/tb_multiplexed_decimal_display_scanner_top.sv
// self-checking testbench of the multiplexed decimal display scanner
`timescale 1ns / 1ps

// predicts scan results and checks them against the block's output transactions
class scan_scoreboard;

    typedef struct {
        logic [mdds_pkg::SLOT_FIELD_W-1:0] slot;
        logic [mdds_pkg::PATTERN_W-1:0]    pattern;
        logic                              counter_reset;
    } scan_t;

    localparam int REPORT_LIMIT = 10;

    logic [mdds_pkg::PATTERN_W-1:0]    digit_codes [mdds_pkg::DIGITS];
    logic [mdds_pkg::PERIOD_W-1:0]     countdown;
    logic [mdds_pkg::PERIOD_W-1:0]     period;
    logic [mdds_pkg::SLOT_FIELD_W-1:0] position;
    logic                              encoding;
    scan_t                             awaited_scans [$];
    int unsigned                       faults;

    function new();
        foreach (digit_codes[k])
            digit_codes[k] = '0;
        countdown = 8'd1;
        position  = '0;
        period    = 8'd2;
        encoding  = mdds_pkg::ENC_BCD;
        faults    = 0;
    endfunction

    // gfedcba pattern of one decimal digit
    static function logic [mdds_pkg::PATTERN_W-1:0] segments_of(input logic [3:0] d);
        case (d)
            4'd0:    return 7'h3F;
            4'd1:    return 7'h06;
            4'd2:    return 7'h5B;
            4'd3:    return 7'h4F;
            4'd4:    return 7'h66;
            4'd5:    return 7'h6D;
            4'd6:    return 7'h7D;
            4'd7:    return 7'h07;
            4'd8:    return 7'h7F;
            4'd9:    return 7'h67;
            default: return 7'h00;
        endcase
    endfunction

    // register write, masked to the register width; unmapped indexes do nothing
    function void note_config(input logic [mdds_pkg::CFG_INDEX_W-1:0] index,
                              input logic [mdds_pkg::CFG_DATA_W-1:0] data);
        if (index == mdds_pkg::REG_REFRESH_PERIOD)
            period = data;
        else if (index == mdds_pkg::REG_DIGIT_ENCODING)
            encoding = data[0];
    endfunction

    // accepted input transaction: load the store or advance the scan
    function void note_input(input logic kind, input logic [mdds_pkg::VALUE_W-1:0] value);
        int unsigned v;
        int          k;
        logic [3:0]  d;
        scan_t       s;
        if (kind == mdds_pkg::KIND_LOAD) begin
            v = value;
            // only the low digits survive, higher ones are simply never reached
            for (k = 0; k < mdds_pkg::DIGITS; k++) begin
                d = 4'(v % 10);
                v = v / 10;
                if (encoding == mdds_pkg::ENC_SEGMENT)
                    digit_codes[k] = segments_of(d);
                else
                    digit_codes[mdds_pkg::DIGITS - 1 - k] = 7'(d);
            end
        end
        else if (countdown != 0) begin
            countdown = countdown - 8'd1;
        end
        else begin
            s.slot          = position;
            s.pattern       = digit_codes[position];
            s.counter_reset = (position == 0);
            awaited_scans.push_back(s);
            if (position == 3'(mdds_pkg::DIGITS - 1))
                position = '0;
            else
                position = position + 3'd1;
            // a zero period behaves as one
            countdown = (period == 0) ? 8'd0 : period - 8'd1;
        end
    endfunction

    function void note_fault(input string msg);
        faults++;
        if (faults <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // accepted output transaction against the oldest prediction
    function void check_result(input logic [mdds_pkg::SLOT_FIELD_W-1:0] slot,
                               input logic [mdds_pkg::PATTERN_W-1:0] pattern,
                               input logic counter_reset);
        scan_t s;
        if (awaited_scans.size() == 0) begin
            note_fault($sformatf("unexpected scan: slot %0d pattern %02h reset %b",
                                 slot, pattern, counter_reset));
        end
        else begin
            s = awaited_scans.pop_front();
            if (slot !== s.slot || pattern !== s.pattern
                || counter_reset !== s.counter_reset)
                note_fault($sformatf({"scan mismatch: expected slot %0d pattern %02h reset %b,",
                                      " got slot %0d pattern %02h reset %b"},
                                     s.slot, s.pattern, s.counter_reset,
                                     slot, pattern, counter_reset));
        end
    endfunction

    function int unsigned outstanding();
        return awaited_scans.size();
    endfunction

    function int unsigned fault_total();
        return faults + awaited_scans.size();
    endfunction

endclass

module tb_multiplexed_decimal_display_scanner_top;

    import mdds_pkg::*;

    localparam int        IDLE_PCT      = 35;
    // a load keeps the block busy through its conversion and store write after acceptance
    localparam int        SETTLE_CYCLES = 48;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = CFG_INDEX_W'(9);

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;  // [31:0] value
    logic                   s_tuser   = 1'b0; // [0] kind
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // [2:0] digit_slot, [9:3] digit_pattern
    logic                   m_tuser;          // [0] counter_reset

    // no idling on either side while set
    logic                   steady    = 1'b0;

    scan_scoreboard sb = new();

    multiplexed_decimal_display_scanner_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result receiver with random back-pressure
    always @(negedge clk)
    begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[SLOT_FIELD_W-1:0],
                            m_tdata[SLOT_FIELD_W +: PATTERN_W], m_tuser);
    end

    // one input transaction, entered and left at a falling edge
    task automatic send_item(input logic kind, input logic [S_TDATA_W-1:0] value);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(kind, value);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, $urandom);
    endtask

    task automatic send_load(input logic [S_TDATA_W-1:0] value);
        send_item(KIND_LOAD, value);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.note_config(index, data);
        @(negedge clk);
    endtask

    // wait for every predicted scan, then let any load conversion finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // random load value, biased towards the edges of the decimal range
    function automatic logic [S_TDATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'd999999;
            2:       return 32'd1000000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return $urandom_range(999999);
            default: return $urandom;
        endcase
    endfunction

    // random mix of loads and ticks
    task automatic run_items(input int count, input int load_pct);
        int n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(99) < load_pct)
                send_load(pick_value());
            else
                send_tick();
        end
    endtask

    // run limit
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // main sequence
    initial
    begin
        int                       ph;
        int                       k;
        logic [PERIOD_W-1:0]      periods   [8];
        logic                     encodings [8];
        int                       counts    [8];
        int                       load_pcts [8];

        periods   = '{8'd1, 8'd2, 8'd255, 8'd0, 8'd5, 8'd1, 8'd3, 8'd1};
        encodings = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        counts    = '{45, 45, 320, 45, 45, 45, 45, 45};
        load_pcts = '{18, 18, 3, 18, 18, 18, 18, 30};

        // reset
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, scanning the cleared store
        for (k = 0; k < 3; k++)
            send_tick();
        settle();

        // zero period fires on every tick
        write_reg(REG_REFRESH_PERIOD, 8'd0);
        send_load(32'hFFFF_FFFF);
        for (k = 0; k < 6; k++)
            send_tick();
        send_load(32'd0);
        send_tick();
        send_load(32'd999999);
        send_tick();
        send_load(32'd1000000);
        send_tick();
        settle();

        // segment mode, masked register data
        write_reg(REG_DIGIT_ENCODING, 8'hFF);
        write_reg(REG_REFRESH_PERIOD, 8'd1);
        send_load(32'd123456);
        for (k = 0; k < 3; k++)
            send_tick();
        settle();

        // mode change keeps the stored patterns, unmapped write is ignored
        write_reg(REG_DIGIT_ENCODING, 8'hFE);
        write_reg(REG_UNMAPPED, 8'h00);
        for (k = 0; k < 4; k++)
            send_tick();

        // random phases over several settings
        for (ph = 0; ph < 8; ph++) begin
            settle();
            write_reg(REG_REFRESH_PERIOD,
                      (ph == 7) ? PERIOD_W'($urandom_range(4, 1)) : periods[ph]);
            write_reg(REG_DIGIT_ENCODING,
                      {7'($urandom), (ph == 7) ? 1'($urandom) : encodings[ph]});
            if ($urandom_range(1) == 1)
                write_reg(CFG_INDEX_W'($urandom_range(15, 2)), 8'($urandom));
            steady <= (ph == 5);
            run_items(counts[ph], load_pcts[ph]);
        end

        settle();
        if (sb.outstanding() != 0)
            $display("predicted scans never seen: %0d", sb.outstanding());
        if (sb.fault_total() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
src/mdds_pkg.sv
src/mdds_datapath.sv
src/mdds_controller.sv
src/multiplexed_decimal_display_scanner_top.sv
src/mdds_checker.sv
sim/tb_multiplexed_decimal_display_scanner_top.sv
